// ----- hw/rtl/wtpg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wtpg_pkg: shared types and constants of the wave trace pixel generator
// Config register indexes, wave kind codes, reset values, config bundles
// and the sine table generator used at elaboration.
// ----------------------------------------------------------------------------
package wtpg_pkg;

   // config register indexes
   localparam logic [2:0] CSR_WAVE_KIND        = 3'd0;
   localparam logic [2:0] CSR_PHASE_SPEED      = 3'd1;
   localparam logic [2:0] CSR_ANGLE_PER_COLUMN = 3'd2;
   localparam logic [2:0] CSR_WAVE_HEIGHT      = 3'd3;
   localparam logic [2:0] CSR_FADE_FACTOR      = 3'd4;

   localparam int CSR_DATA_W = 17;

   typedef enum logic [2:0] {
      WAVE_SINE     = 3'd0,
      WAVE_COSINE   = 3'd1,
      WAVE_TANGENT  = 3'd2,
      WAVE_SQUARE   = 3'd3,
      WAVE_SAWTOOTH = 3'd4,
      WAVE_TRIANGLE = 3'd5
   } wave_kind_type;

   localparam logic [2:0]  RESET_WAVE_KIND        = WAVE_SINE;
   localparam logic [16:0] RESET_PHASE_SPEED      = 17'd3277;
   localparam logic [13:0] RESET_ANGLE_PER_COLUMN = 14'd1043;
   localparam logic [8:0]  RESET_WAVE_HEIGHT      = 9'd240;
   localparam logic [7:0]  RESET_FADE_FACTOR      = 8'd230;

   // wave values are Q1.15 in 17-bit two's complement (+-1.0 included)
   localparam int WAVE_W = 17;
   localparam logic signed [WAVE_W-1:0] WAVE_ONE = 17'sd32768;

   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   typedef struct packed {
      logic [16:0] phase_speed;
      logic [13:0] angle_per_column;
   } front_cfg_type;

   typedef struct packed {
      logic [2:0] wave_kind;
      logic [8:0] wave_height;
      logic [7:0] fade_factor;
   } back_cfg_type;

   // sin(pi/2 * j / 2^qshift) in Q1.15; Q30 Taylor series, odd terms to x^11
   function automatic longint quarter_sine(input longint j, input int qshift);
      longint x;
      longint x2;
      longint term;
      longint sum;
      longint r;
      x    = (HALF_PI_Q30 * j) >>> qshift;
      x2   = (x * x) >>> 30;
      sum  = x;
      term = ((x * x2) >>> 30) / 6;
      sum  = sum - term;
      term = ((term * x2) >>> 30) / 20;
      sum  = sum + term;
      term = ((term * x2) >>> 30) / 42;
      sum  = sum - term;
      term = ((term * x2) >>> 30) / 72;
      sum  = sum + term;
      term = ((term * x2) >>> 30) / 110;
      sum  = sum - term;
      if (sum < 0) begin
         sum = 0;
      end
      r = (sum + 64'sd16384) >>> 15;
      if (r > 64'sd32768) begin
         r = 64'sd32768;
      end
      return r;
   endfunction

   // full-turn sine entry k of a 2^bits table, built from the quarter wave
   function automatic logic signed [WAVE_W-1:0] sine_entry(input int k, input int bits);
      int     qshift;
      longint quarter;
      longint quad;
      longint j;
      longint s;
      qshift  = bits - 2;
      quarter = 64'sd1 <<< qshift;
      quad    = longint'(k) >>> qshift;
      j       = longint'(k) & (quarter - 1);
      s       = quad[0] ? quarter_sine(quarter - j, qshift) : quarter_sine(j, qshift);
      if (quad[1]) begin
         s = -s;
      end
      return WAVE_W'(s);
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/wtpg_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wtpg_queue: small FIFO between front and back
// Register-based queue with show-ahead read; push and pop can happen in the same cycle.
// ----------------------------------------------------------------------------
module wtpg_queue
   import wtpg_pkg::*;
#(
   parameter int WIDTH = 45,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  full,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            slot_ff[wr_ptr_ff] <= push_data;
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/wtpg_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wtpg_front: request intake and classification
// Accepts pixel requests, flags in-matrix and end-of-frame pixels, owns the
// phase register and forms the wave angle for the queue.
// ----------------------------------------------------------------------------
module wtpg_front
   import wtpg_pkg::*;
#(
   parameter int COLUMNS = 64,
   parameter int ROWS    = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [$clog2(COLUMNS)-1:0]        req_column,
   input  wire logic [$clog2(ROWS)-1:0]           req_pixel_row,
   input  wire front_cfg_type                     cfg,
   input  wire logic                              clearing,
   input  wire logic                              q_full,
   output logic                                   q_push,
   output logic [$clog2(COLUMNS)+$clog2(ROWS)+33:0] q_data
);

   localparam int CW = $clog2(COLUMNS);
   localparam int RW = $clog2(ROWS);

   logic          accept;
   logic          in_matrix;
   logic          last_pixel;
   logic [31:0]   pos;
   logic [45:0]   angle_prod;

   logic          s1_valid_ff;
   logic [CW-1:0] s1_col_ff;
   logic [RW-1:0] s1_row_ff;
   logic [31:0]   s1_pos_ff;
   logic          s1_inm_ff;
   logic          s1_last_ff;
   logic [31:0]   phase_ff;

   assign req_stall  = clearing | (s1_valid_ff & q_full);
   assign accept     = req_valid & ~req_stall;
   assign in_matrix  = ({1'b0, req_column} < (CW + 1)'(COLUMNS)) &&
                       ({1'b0, req_pixel_row} < (RW + 1)'(ROWS));
   assign last_pixel = in_matrix && (req_column == CW'(COLUMNS - 1)) &&
                       (req_pixel_row == RW'(ROWS - 1));
   // Q16.16 column position
   assign pos        = (32'(req_column) << 16) + phase_ff;

   // only the low 32 bits of the angle matter (fraction of a turn)
   assign angle_prod = 46'(s1_pos_ff) * 46'(cfg.angle_per_column);
   assign q_push     = s1_valid_ff & ~q_full;
   assign q_data     = {s1_inm_ff, s1_last_ff, angle_prod[31:0], s1_row_ff, s1_col_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         phase_ff    <= '0;
      end else begin
         s1_valid_ff <= accept | (s1_valid_ff & ~q_push);
         if (accept) begin
            s1_col_ff   <= req_column;
            s1_row_ff   <= req_pixel_row;
            s1_pos_ff   <= pos;
            s1_inm_ff   <= in_matrix;
            s1_last_ff  <= last_pixel;
            if (last_pixel) begin
               phase_ff <= phase_ff + 32'(cfg.phase_speed);
            end
         end
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/wtpg_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wtpg_back: wave evaluation, trace match and frame store update
// Sequencer per pixel: table lookup and store read, wave value (with a
// bit-serial divider for tangent), trace row, colour and write-back.
// ----------------------------------------------------------------------------
module wtpg_back
   import wtpg_pkg::*;
#(
   parameter int COLUMNS          = 64,
   parameter int ROWS             = 32,
   parameter int ANGLE_TABLE_BITS = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire back_cfg_type                        cfg,
   input  wire logic [$clog2(COLUMNS)+$clog2(ROWS)+33:0] q_data,
   input  wire logic                                q_empty,
   output logic                                     q_pop,
   output logic                                     clearing,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [$clog2(COLUMNS)-1:0]               rsp_out_column,
   output logic [$clog2(ROWS)-1:0]                  rsp_out_row,
   output logic [7:0]                               rsp_red,
   output logic [7:0]                               rsp_green,
   output logic [7:0]                               rsp_blue,
   output logic                                     rsp_frame_done
);

   localparam int CW         = $clog2(COLUMNS);
   localparam int RW         = $clog2(ROWS);
   localparam int DEPTH      = COLUMNS * ROWS;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int TABLE_SIZE = 1 << ANGLE_TABLE_BITS;
   localparam int QUARTER    = TABLE_SIZE >> 2;
   localparam int ROWS_M1    = ROWS - 1;
   localparam int ROWS16     = ROWS * 16;
   localparam int TB         = ANGLE_TABLE_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_WAVE,
      ST_DIVIDE,
      ST_TRACE,
      ST_WRITE
   } state_type;

   // constant tables
   logic signed [WAVE_W-1:0] sine_rom [TABLE_SIZE];
   logic [7:0]               red_rom  [ROWS];
   logic [7:0]               blue_rom [ROWS];

   for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_sine
      assign sine_rom[g] = sine_entry(g, ANGLE_TABLE_BITS);
   end
   for (genvar g = 0; g < ROWS; g++) begin : g_grad
      assign red_rom[g]  = 8'((255 * (ROWS_M1 - g)) / ROWS_M1);
      assign blue_rom[g] = 8'((255 * g) / ROWS_M1);
   end

   // frame store
   logic [23:0]       store_mem [DEPTH];
   logic [23:0]       mem_rdata_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [23:0]       mem_wdata;
   logic              mem_re;

   // sequencer state
   state_type                state_ff;
   logic                     clr_active_ff;
   logic [ADDR_W-1:0]        clr_addr_ff;
   logic [CW-1:0]            col_ff;
   logic [RW-1:0]            row_ff;
   logic [31:0]              angle_ff;
   logic                     done_ff;
   logic                     inm_ff;
   logic [ADDR_W-1:0]        addr_ff;
   logic signed [WAVE_W-1:0] s_ff;
   logic signed [WAVE_W-1:0] c_ff;
   logic signed [WAVE_W-1:0] v_ff;
   logic                     on_trace_ff;
   logic [16:0]              div_rem_ff;
   logic [16:0]              div_den_ff;
   logic [14:0]              div_quo_ff;
   logic [3:0]               div_cnt_ff;
   logic                     div_neg_ff;

   logic                     rsp_valid_ff;
   logic [CW-1:0]            rsp_col_ff;
   logic [RW-1:0]            rsp_row_ff;
   logic [7:0]               rsp_red_ff;
   logic [7:0]               rsp_green_ff;
   logic [7:0]               rsp_blue_ff;
   logic                     rsp_done_ff;

   // queue entry fields
   logic [CW-1:0]     pop_col;
   logic [RW-1:0]     pop_row;
   logic [ADDR_W-1:0] pop_addr;

   assign pop_col  = q_data[CW-1:0];
   assign pop_row  = q_data[CW +: RW];
   assign pop_addr = ADDR_W'(32'(pop_col) * ROWS) + ADDR_W'(pop_row);

   assign clearing = clr_active_ff;
   assign q_pop    = (state_ff == ST_IDLE) && !clr_active_ff && !q_empty;

   // table lookup
   logic [TB-1:0] sin_idx;
   logic [TB-1:0] cos_idx;

   assign sin_idx = angle_ff[31 -: TB];
   assign cos_idx = sin_idx + TB'(QUARTER);

   // wave value
   logic [16:0]              mag_s;
   logic [16:0]              mag_c;
   logic                     tan_neg;
   logic [15:0]              saw_u;
   logic [15:0]              tri_u;
   logic signed [WAVE_W-1:0] wave_v;
   logic                     wave_div;

   assign mag_s   = s_ff[WAVE_W-1] ? 17'(-s_ff) : 17'(s_ff);
   assign mag_c   = c_ff[WAVE_W-1] ? 17'(-c_ff) : 17'(c_ff);
   assign tan_neg = (s_ff[WAVE_W-1] != c_ff[WAVE_W-1]) && (s_ff != '0);
   assign saw_u   = angle_ff[31:16];
   assign tri_u   = (saw_u > 16'd32768) ? 16'(17'd65536 - 17'(saw_u)) : saw_u;

   always_comb begin
      wave_v   = s_ff;
      wave_div = 1'b0;
      unique case (cfg.wave_kind)
         WAVE_SINE: begin
            wave_v = s_ff;
         end
         WAVE_COSINE: begin
            wave_v = c_ff;
         end
         WAVE_TANGENT: begin
            // clip to +-1 when |tan| >= 1 or cos is zero
            if (c_ff == '0 || mag_s >= mag_c) begin
               wave_v = tan_neg ? -WAVE_ONE : WAVE_ONE;
            end else begin
               wave_div = 1'b1;
            end
         end
         WAVE_SQUARE: begin
            wave_v = (angle_ff != '0 && !angle_ff[31]) ? WAVE_ONE : -WAVE_ONE;
         end
         WAVE_SAWTOOTH: begin
            wave_v = signed'({1'b0, saw_u}) - WAVE_ONE;
         end
         WAVE_TRIANGLE: begin
            wave_v = signed'({tri_u, 1'b0}) - WAVE_ONE;
         end
         default: begin
            wave_v = s_ff;
         end
      endcase
   end

   // restoring divider step: remainder stays below the divisor
   logic [16:0] div_shift;
   logic        div_ge;
   logic [14:0] div_q_final;

   assign div_shift   = {div_rem_ff[15:0], 1'b0};
   assign div_ge      = (div_shift >= div_den_ff);
   assign div_q_final = {div_quo_ff[13:0], div_ge};

   // trace row
   logic [16:0]   v_plus;
   logic [25:0]   trace_prod;
   logic [27:0]   trace_sum;
   logic [6:0]    trace_hi;
   logic [RW-1:0] trace_y;

   assign v_plus     = 17'(unsigned'(v_ff) + 17'd32768);
   assign trace_prod = 26'(v_plus) * 26'(cfg.wave_height);
   assign trace_sum  = 28'(trace_prod) + (28'(ROWS16) << 15) - (28'(cfg.wave_height) << 15);
   assign trace_hi   = trace_sum[26:20];
   assign trace_y    = trace_sum[27] ? '0 :
                       (trace_hi >= 7'(ROWS)) ? RW'(ROWS - 1) : RW'(trace_hi);

   // colour
   logic [15:0] fade_r;
   logic [15:0] fade_g;
   logic [15:0] fade_b;
   logic [7:0]  new_r;
   logic [7:0]  new_g;
   logic [7:0]  new_b;
   logic        out_free;
   logic        rsp_load;

   assign fade_r   = mem_rdata_ff[23:16] * cfg.fade_factor;
   assign fade_g   = mem_rdata_ff[15:8] * cfg.fade_factor;
   assign fade_b   = mem_rdata_ff[7:0] * cfg.fade_factor;
   assign new_r    = !inm_ff ? '0 : on_trace_ff ? red_rom[row_ff] : fade_r[15:8];
   assign new_g    = (!inm_ff || on_trace_ff) ? '0 : fade_g[15:8];
   assign new_b    = !inm_ff ? '0 : on_trace_ff ? blue_rom[row_ff] : fade_b[15:8];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = (state_ff == ST_WRITE) && out_free;

   assign mem_re    = (state_ff == ST_LOOKUP);
   assign mem_we    = clr_active_ff || ((state_ff == ST_WRITE) && out_free && inm_ff);
   assign mem_waddr = clr_active_ff ? clr_addr_ff : addr_ff;
   assign mem_wdata = clr_active_ff ? '0 : {new_r, new_g, new_b};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= store_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (clr_active_ff) begin
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               clr_active_ff <= 1'b0;
            end else begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  col_ff   <= pop_col;
                  row_ff   <= pop_row;
                  angle_ff <= q_data[CW+RW +: 32];
                  done_ff  <= q_data[CW+RW+32];
                  inm_ff   <= q_data[CW+RW+33];
                  addr_ff  <= pop_addr;
                  state_ff <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               s_ff     <= sine_rom[sin_idx];
               c_ff     <= sine_rom[cos_idx];
               state_ff <= inm_ff ? ST_WAVE : ST_WRITE;
            end
            ST_WAVE: begin
               if (wave_div) begin
                  div_rem_ff <= mag_s;
                  div_den_ff <= mag_c;
                  div_quo_ff <= '0;
                  div_cnt_ff <= '0;
                  div_neg_ff <= tan_neg;
                  state_ff   <= ST_DIVIDE;
               end else begin
                  v_ff     <= wave_v;
                  state_ff <= ST_TRACE;
               end
            end
            ST_DIVIDE: begin
               div_rem_ff <= div_ge ? div_shift - div_den_ff : div_shift;
               div_quo_ff <= div_q_final;
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == 4'd14) begin
                  v_ff     <= div_neg_ff ? -signed'(17'(div_q_final)) : signed'(17'(div_q_final));
                  state_ff <= ST_TRACE;
               end
            end
            ST_TRACE: begin
               on_trace_ff <= (row_ff == trace_y);
               state_ff    <= ST_WRITE;
            end
            ST_WRITE: begin
               if (out_free) begin
                  rsp_col_ff   <= col_ff;
                  rsp_row_ff   <= row_ff;
                  rsp_red_ff   <= new_r;
                  rsp_green_ff <= new_g;
                  rsp_blue_ff  <= new_b;
                  rsp_done_ff  <= done_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_column = rsp_col_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_red        = rsp_red_ff;
   assign rsp_green      = rsp_green_ff;
   assign rsp_blue       = rsp_blue_ff;
   assign rsp_frame_done = rsp_done_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/wave_trace_pixel_generator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wave_trace_pixel_generator: animated waveform trace with fading trail
// Takes one pixel position per request, evaluates the selected waveform at
// that column and returns the pixel colour, updating the frame store.
//
// Usage:
//   req_*  : pixel request (column, row); taken when req_valid && !req_stall.
//   rsp_*  : pixel result; taken when rsp_valid && !rsp_stall. Results come
//            back one per request, in request order.
//   csr_*  : register writes, taken when csr_valid && csr_ready (always
//            ready); write only while no request is in flight.
// A request passes the front register, the queue and the back sequencer
// into the result register. The front takes a request every cycle while
// req_stall is low, into a 4-entry queue; the back takes one pixel at a
// time through lookup, wave (bit-serial divide for a tangent below the
// clip), trace and write, which sets the sustained rate. Reset clears the
// phase and the result valid flag, then a clearing pass zeroes all
// COLUMNS*ROWS store entries (2048 at default size), one per cycle, with
// req_stall high. If rsp_stall holds, the result is held while the back
// finishes the next pixel; req_stall rises once queue and front are full.
// ----------------------------------------------------------------------------
module wave_trace_pixel_generator
   import wtpg_pkg::*;
#(
   parameter int COLUMNS          = 64,
   parameter int ROWS             = 32,
   parameter int ANGLE_TABLE_BITS = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [$clog2(COLUMNS)-1:0]   req_column,
   input  wire logic [$clog2(ROWS)-1:0]      req_pixel_row,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [$clog2(COLUMNS)-1:0]        rsp_out_column,
   output logic [$clog2(ROWS)-1:0]           rsp_out_row,
   output logic [7:0]                        rsp_red,
   output logic [7:0]                        rsp_green,
   output logic [7:0]                        rsp_blue,
   output logic                              rsp_frame_done,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [2:0]                   csr_index,
   input  wire logic [CSR_DATA_W-1:0]        csr_data
);

   localparam int CW          = $clog2(COLUMNS);
   localparam int RW          = $clog2(ROWS);
   localparam int ENTRY_W     = CW + RW + 34;
   localparam int QUEUE_DEPTH = 4;

   logic [2:0]  wave_kind_ff;
   logic [16:0] phase_speed_ff;
   logic [13:0] angle_per_column_ff;
   logic [8:0]  wave_height_ff;
   logic [7:0]  fade_factor_ff;

   front_cfg_type        front_cfg;
   back_cfg_type         back_cfg;
   logic                 clearing;
   logic                 q_push;
   logic                 q_pop;
   logic                 q_full;
   logic                 q_empty;
   logic [ENTRY_W-1:0]   q_push_data;
   logic [ENTRY_W-1:0]   q_pop_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_kind_ff        <= RESET_WAVE_KIND;
         phase_speed_ff      <= RESET_PHASE_SPEED;
         angle_per_column_ff <= RESET_ANGLE_PER_COLUMN;
         wave_height_ff      <= RESET_WAVE_HEIGHT;
         fade_factor_ff      <= RESET_FADE_FACTOR;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WAVE_KIND:        wave_kind_ff        <= csr_data[2:0];
            CSR_PHASE_SPEED:      phase_speed_ff      <= csr_data[16:0];
            CSR_ANGLE_PER_COLUMN: angle_per_column_ff <= csr_data[13:0];
            CSR_WAVE_HEIGHT:      wave_height_ff      <= csr_data[8:0];
            CSR_FADE_FACTOR:      fade_factor_ff      <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   assign front_cfg.phase_speed      = phase_speed_ff;
   assign front_cfg.angle_per_column = angle_per_column_ff;
   assign back_cfg.wave_kind         = wave_kind_ff;
   assign back_cfg.wave_height       = wave_height_ff;
   assign back_cfg.fade_factor       = fade_factor_ff;

   wtpg_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_column    (req_column),
      .req_pixel_row (req_pixel_row),
      .cfg           (front_cfg),
      .clearing      (clearing),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (q_push_data)
   );

   wtpg_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   wtpg_back #(
      .COLUMNS          (COLUMNS),
      .ROWS             (ROWS),
      .ANGLE_TABLE_BITS (ANGLE_TABLE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (back_cfg),
      .q_data         (q_pop_data),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .clearing       (clearing),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_column (rsp_out_column),
      .rsp_out_row    (rsp_out_row),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_frame_done (rsp_frame_done)
   );

   // end of frame is only ever flagged on the bottom-right pixel
   a_frame_done_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |->
         (rsp_out_column == CW'(COLUMNS - 1) && rsp_out_row == RW'(ROWS - 1)))
      else $error("frame_done on a pixel other than the last one");

   // green is never produced, and fading keeps it at zero in the store
   a_green_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_green == 8'd0))
      else $error("nonzero green in a result");

   // a pixel outside the matrix returns black and no end of frame
   a_outside_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (({1'b0, rsp_out_column} >= (CW + 1)'(COLUMNS)) ||
                     ({1'b0, rsp_out_row} >= (RW + 1)'(ROWS)))) |->
         (rsp_red == 8'd0 && rsp_blue == 8'd0 && !rsp_frame_done))
      else $error("outside pixel returned a colour");

   // no request is taken and no result shown while the store is being cleared
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clearing |-> (req_stall && !rsp_valid && !q_push))
      else $error("activity during frame store clearing");

endmodule
`default_nettype wire
